>>> rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants for the text console writer: grid defaults, character
// codes, mode codes and stream field layout.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int COLUMNS_DEF   = 80;
    localparam int ROWS_DEF      = 25;
    localparam int TAB_WIDTH_DEF = 8;

    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;

    localparam logic MODE_PUT  = 1'b0;
    localparam logic MODE_READ = 1'b1;

    localparam int CHAR_W   = 8;
    localparam int INDEX_W  = 11;
    localparam int CURSOR_W = 11;

    // s_tdata: char_code, cell_index; m_tdata: cell_char, cursor_pos, scrolled
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 24;
    localparam int M_PAD_W   = M_TDATA_W - CHAR_W - CURSOR_W - 1;

endpackage

>>> rtl/text_console_writer.sv
// Steps: a glyph put passes EXEC, WRITE and DONE; a newline EXEC and DONE; a tab EXEC,
//   TAB_NORM (repeated while the column needs wrapping) and DONE; a read RD_ADDR,
//   RD_MEM, RD_DATA and DONE. A put with the cursor past the last cell first scrolls
//   (row-offset ring, one blank written per cycle). Items are handled one at a time;
//   the single shared add/wrap unit and the one-port cell memory set the steps. A new
//   item is taken while a result waits. Reset: synchronous, active low; then a clearing
//   pass fills every cell with a space while s_tready stays low.
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode screen writer: character grid in a memory addressed through a
// row-offset ring, cursor handling for newline, tab and glyphs, cell readback.
// ----------------------------------------------------------------------------
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS   = COLUMNS_DEF,
    parameter int ROWS      = ROWS_DEF,
    parameter int TAB_WIDTH = TAB_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [7:0] char_code, [18:8] cell_index
    input  logic                 s_tuser,   // [0] mode
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // [7:0] cell_char, [18:8] cursor_pos,
                                            // [19] scrolled
);

    localparam int CELLS      = COLUMNS * ROWS;
    localparam int LAST_START = COLUMNS * (ROWS - 1);
    localparam int STEP_MAX   = (COLUMNS > TAB_WIDTH) ? COLUMNS : TAB_WIDTH;
    localparam int CUR_MAX    = 2 * CELLS + STEP_MAX;
    localparam int CUR_W      = $clog2(CUR_MAX + 1);
    localparam int SUM_W      = CUR_W + 1;
    localparam int ADDR_W     = $clog2(CELLS);
    localparam int COL_W      = $clog2(COLUMNS + TAB_WIDTH);
    localparam int CNT_W      = $clog2(COLUMNS);

    localparam logic [SUM_W-1:0]  CELLS_S   = SUM_W'(CELLS);
    localparam logic [SUM_W-1:0]  COLS_S    = SUM_W'(COLUMNS);
    localparam logic [SUM_W-1:0]  LAST_S    = SUM_W'(LAST_START);
    localparam logic [SUM_W-1:0]  TAB_S     = SUM_W'(TAB_WIDTH);
    localparam logic [CUR_W-1:0]  CELLS_C   = CUR_W'(CELLS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
    localparam logic [CNT_W-1:0]  LAST_CNT  = CNT_W'(COLUMNS - 1);
    localparam logic [COL_W-1:0]  COLS_W    = COL_W'(COLUMNS);
    localparam logic [COL_W-1:0]  TAB_W     = COL_W'(TAB_WIDTH);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCR_MOD,
        ST_SCR_ADD,
        ST_SCR_ROW,
        ST_EXEC,
        ST_WRITE,
        ST_TAB_NORM,
        ST_RD_ADDR,
        ST_RD_MEM,
        ST_RD_DATA,
        ST_DONE
    } state_t;

    state_t                 state_reg,    state_next;
    logic [CUR_W-1:0]       cursor_reg,   cursor_next;
    logic [COL_W-1:0]       ccol_reg,     ccol_next;
    logic [ADDR_W-1:0]      top_off_reg,  top_off_next;
    logic [ADDR_W-1:0]      addr_reg,     addr_next;
    logic [CNT_W-1:0]       cnt_reg,      cnt_next;
    logic [CHAR_W-1:0]      code_reg,     code_next;
    logic [INDEX_W-1:0]     idx_reg,      idx_next;
    logic [CHAR_W-1:0]      res_char_reg, res_char_next;
    logic                   res_scr_reg,  res_scr_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]   m_tdata_reg,  m_tdata_next;

    logic [CHAR_W-1:0]      mem [CELLS];
    logic [CHAR_W-1:0]      rd_data_reg;
    logic                   mem_we;
    logic [CHAR_W-1:0]      mem_wdata;

    // shared add/wrap unit
    logic [SUM_W-1:0]       au_a, au_b, au_mod, au_sum, au_res;
    logic                   au_wrap, au_ge;

    logic                   cur_in_grid;
    logic                   idx_in_grid;
    logic [COL_W-1:0]       ccol_inc, ccol_adv;
    logic                   s_take;

    assign s_tready    = (state_reg == ST_IDLE);
    assign m_tvalid    = m_tvalid_reg;
    assign m_tdata     = m_tdata_reg;
    assign s_take      = s_tvalid && s_tready;

    assign cur_in_grid = (cursor_reg < CELLS_C);
    assign idx_in_grid = (32'(idx_reg) < 32'(CELLS));
    assign ccol_inc    = ccol_reg + COL_W'(1);
    assign ccol_adv    = (ccol_inc == COLS_W) ? '0 : ccol_inc;

    assign au_sum = au_a + au_b;
    assign au_ge  = (au_sum >= au_mod);
    assign au_res = (au_wrap && au_ge) ? (au_sum - au_mod) : au_sum;

    always_comb begin
        au_a    = '0;
        au_b    = '0;
        au_mod  = CELLS_S;
        au_wrap = 1'b1;
        case (state_reg)
            ST_SCR_MOD: begin
                au_a = SUM_W'(cursor_reg);
            end
            ST_SCR_ADD: begin
                au_a    = SUM_W'(cursor_reg);
                au_b    = LAST_S;
                au_wrap = 1'b0;
            end
            ST_SCR_ROW: begin
                au_a = SUM_W'(top_off_reg);
                au_b = COLS_S;
            end
            ST_EXEC: begin
                au_a    = SUM_W'(cursor_reg);
                au_wrap = 1'b0;
                case (code_reg)
                    CHAR_NEWLINE: au_b = COLS_S - SUM_W'(ccol_reg);
                    CHAR_TAB:     au_b = TAB_S;
                    default: begin
                        if (cur_in_grid) begin
                            au_b    = SUM_W'(top_off_reg);
                            au_wrap = 1'b1;
                        end else begin
                            au_b = SUM_W'(1);
                        end
                    end
                endcase
            end
            ST_WRITE: begin
                au_a    = SUM_W'(cursor_reg);
                au_b    = SUM_W'(1);
                au_wrap = 1'b0;
            end
            ST_TAB_NORM: begin
                au_a   = SUM_W'(ccol_reg);
                au_mod = COLS_S;
            end
            ST_RD_ADDR: begin
                au_a = SUM_W'(idx_reg);
                au_b = SUM_W'(top_off_reg);
            end
            default: begin
                au_a = '0;
            end
        endcase
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = CHAR_SPACE;
        case (state_reg)
            ST_CLEAR, ST_SCR_ROW: mem_we = 1'b1;
            ST_WRITE: begin
                mem_we    = 1'b1;
                mem_wdata = code_reg;
            end
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[addr_reg] <= mem_wdata;
        end
        rd_data_reg <= mem[addr_reg];
    end

    always_comb begin
        state_next    = state_reg;
        cursor_next   = cursor_reg;
        ccol_next     = ccol_reg;
        top_off_next  = top_off_reg;
        addr_next     = addr_reg;
        cnt_next      = cnt_reg;
        code_next     = code_reg;
        idx_next      = idx_reg;
        res_char_next = res_char_reg;
        res_scr_next  = res_scr_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;

        case (state_reg)
            ST_CLEAR: begin
                addr_next = addr_reg + ADDR_W'(1);
                if (addr_reg == LAST_ADDR) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_take) begin
                    code_next     = s_tdata[CHAR_W-1:0];
                    idx_next      = s_tdata[CHAR_W +: INDEX_W];
                    res_char_next = '0;
                    res_scr_next  = 1'b0;
                    if (s_tuser == MODE_READ) begin
                        state_next = ST_RD_ADDR;
                    end else if (s_tdata[CHAR_W-1:0] == CHAR_NUL) begin
                        state_next = ST_DONE;
                    end else if (!cur_in_grid) begin
                        state_next = ST_SCR_MOD;
                    end else begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_SCR_MOD: begin
                // reduce the cursor below the cell count, one subtract a cycle
                res_scr_next = 1'b1;
                if (au_ge) begin
                    cursor_next = CUR_W'(au_res);
                end else begin
                    state_next = ST_SCR_ADD;
                end
            end
            ST_SCR_ADD: begin
                cursor_next = CUR_W'(au_res);
                addr_next   = top_off_reg;
                cnt_next    = '0;
                state_next  = ST_SCR_ROW;
            end
            ST_SCR_ROW: begin
                // blank the old top row, which becomes the new bottom row
                addr_next = addr_reg + ADDR_W'(1);
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == LAST_CNT) begin
                    top_off_next = ADDR_W'(au_res);
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (code_reg)
                    CHAR_NEWLINE: begin
                        cursor_next = CUR_W'(au_res);
                        ccol_next   = '0;
                        state_next  = ST_DONE;
                    end
                    CHAR_TAB: begin
                        cursor_next = CUR_W'(au_res);
                        ccol_next   = ccol_reg + TAB_W;
                        state_next  = ST_TAB_NORM;
                    end
                    default: begin
                        if (cur_in_grid) begin
                            addr_next  = ADDR_W'(au_res);
                            state_next = ST_WRITE;
                        end else begin
                            // drop the glyph, still advance
                            cursor_next = CUR_W'(au_res);
                            ccol_next   = ccol_adv;
                            state_next  = ST_DONE;
                        end
                    end
                endcase
            end
            ST_WRITE: begin
                cursor_next = CUR_W'(au_res);
                ccol_next   = ccol_adv;
                state_next  = ST_DONE;
            end
            ST_TAB_NORM: begin
                if (au_ge) begin
                    ccol_next = COL_W'(au_res);
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_RD_ADDR: begin
                addr_next  = ADDR_W'(au_res);
                state_next = ST_RD_MEM;
            end
            ST_RD_MEM: begin
                state_next = ST_RD_DATA;
            end
            ST_RD_DATA: begin
                res_char_next = idx_in_grid ? rd_data_reg : '0;
                state_next    = ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{M_PAD_W{1'b0}}, res_scr_reg,
                                     CURSOR_W'(cursor_reg), res_char_reg};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            cursor_reg   <= '0;
            ccol_reg     <= '0;
            top_off_reg  <= '0;
            addr_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cursor_reg   <= cursor_next;
            ccol_reg     <= ccol_next;
            top_off_reg  <= top_off_next;
            addr_reg     <= addr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        cnt_reg      <= cnt_next;
        code_reg     <= code_next;
        idx_reg      <= idx_next;
        res_char_reg <= res_char_next;
        res_scr_reg  <= res_scr_next;
        m_tdata_reg  <= m_tdata_next;
    end

endmodule

>>> rtl/tcw_checker.sv
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks for the text console writer, bound to the top level.
// ----------------------------------------------------------------------------
module tcw_checker
    import tcw_pkg::*;
#(
    parameter int COLUMNS   = COLUMNS_DEF,
    parameter int ROWS      = ROWS_DEF,
    parameter int TAB_WIDTH = TAB_WIDTH_DEF
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    localparam int CELLS    = COLUMNS * ROWS;
    localparam int STEP_MAX = (COLUMNS > TAB_WIDTH) ? COLUMNS : TAB_WIDTH;
    localparam bit FITS     = (2 * CELLS + STEP_MAX) < (1 << CURSOR_W);
    localparam logic [CURSOR_W-1:0] LAST_START = CURSOR_W'(COLUMNS * (ROWS - 1));

    // reset starts the clearing pass: nothing accepted, nothing offered
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_tready && !m_tvalid)
        else $error("tcw: ready or valid right after reset");

    // one item at a time: an accepted beat closes the input until the item is done
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("tcw: input still ready after accepting a beat");

    // a scrolled put leaves the cursor on the last row or beyond
    a_scroll_cursor: assert property (@(posedge aclk) disable iff (!aresetn)
        FITS && m_tvalid && m_tdata[CHAR_W+CURSOR_W] |->
            m_tdata[CHAR_W +: CURSOR_W] >= LAST_START)
        else $error("tcw: scrolled result with cursor above last row");

    // a nonzero character only comes from a read, which never scrolls
    a_read_no_scroll: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[CHAR_W-1:0] != CHAR_NUL) |-> !m_tdata[CHAR_W+CURSOR_W])
        else $error("tcw: read result marked as scrolled");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("tcw: result beat dropped or changed while stalled");

endmodule

bind text_console_writer tcw_checker #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TAB_WIDTH (TAB_WIDTH)
) u_tcw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
